// ===== sv/lrtjs_pkg.sv =====
package lrtjs_pkg;

   localparam int JOBS_DEFAULT  = 32;
   localparam int ID_W          = 31;
   localparam int SLICE_W       = 8;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;
   localparam int RESULT_CAP    = 32;
   localparam int ENTRY_W       = 3 * ID_W;

   typedef enum logic [2:0] {
      MODE_INSERT = 3'd0,
      MODE_TICK   = 3'd1,
      MODE_LOOKUP = 3'd2,
      MODE_RANGE  = 3'd3,
      MODE_NEXT   = 3'd4,
      MODE_PREV   = 3'd5
   } mode_type;

   localparam logic [0:0] REG_TIME_SLICE = 1'd0;

   typedef struct packed {
      logic [2:0]      mode;
      logic [ID_W-1:0] job_id;
      logic [ID_W-1:0] time_or_upper;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] out_job_id;
      logic [ID_W-1:0] executed_time;
      logic [ID_W-1:0] need_time;
      logic            found;
      logic            last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_ACT,
      ST_EMIT,
      ST_WAIT
   } state_type;

endpackage

// ===== sv/least_run_time_job_scheduler.sv =====
// Each accepted request is handled in turn: the table is scanned through one
// read port, then the act step (insert or tick writeback) runs and queries emit.
// One request at a time; req_stall is held while busy. Each further range result
// takes another full table scan, and a stalled output holds the result.
// Reset: synchronous, active high; clears valid bits, dispatch state and
// restores time_slice to 5. Job memory contents stay undefined until written.
module least_run_time_job_scheduler #(
   parameter int JOBS = lrtjs_pkg::JOBS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lrtjs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lrtjs_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import lrtjs_pkg::*;

   localparam int AW = $clog2(JOBS);
   localparam int CW = $clog2(JOBS + 1);
   localparam int KW = $clog2(RESULT_CAP + 1);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [JOBS-1:0] valid_ff;
   logic [SLICE_W-1:0] slice_cfg_ff;
   logic running_ff;
   logic [AW-1:0] run_slot_ff;
   logic [SLICE_W-1:0] slice_left_ff;

   logic [CW-1:0] scan_ff;
   logic [AW-1:0] rd_slot_ff;
   logic          rd_pend_ff;
   logic          best_ok_ff;
   logic          more_ff;
   logic [AW-1:0] best_slot_ff;
   logic [ID_W-1:0] best_id_ff, best_ex_ff, best_tot_ff;
   logic          free_ok_ff;
   logic [AW-1:0] free_slot_ff;
   logic          dup_ff;
   logic [ID_W:0] lo_ff;
   logic [KW-1:0] count_ff;
   logic          tick_run_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [ID_W-1:0] e_id, e_ex, e_tot;

   lrtjs_ram #(.WIDTH(ENTRY_W), .DEPTH(JOBS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign {e_id, e_ex, e_tot} = rd_data;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-SLICE_W){1'b0}}, slice_cfg_ff};
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   logic scan_done;
   assign scan_done = (scan_ff == CW'(JOBS));
   assign rd_addr   = scan_done ? run_slot_ff : scan_ff[AW-1:0];

   logic cand;
   logic better;
   logic [ID_W:0] e_id_x;
   assign e_id_x = {1'b0, e_id};
   always_comb begin
      cand   = rd_pend_ff && valid_ff[rd_slot_ff];
      better = 1'b0;
      case (req_ff.mode)
         MODE_TICK: better = !best_ok_ff || e_ex < best_ex_ff ||
                             (e_ex == best_ex_ff && e_id < best_id_ff);
         MODE_LOOKUP: begin
            cand   = cand && e_id == req_ff.job_id && !best_ok_ff;
            better = 1'b1;
         end
         MODE_RANGE: begin
            cand   = cand && e_id_x >= lo_ff && e_id <= req_ff.time_or_upper;
            better = !best_ok_ff || e_id < best_id_ff;
         end
         MODE_NEXT: begin
            cand   = cand && e_id > req_ff.job_id;
            better = !best_ok_ff || e_id < best_id_ff;
         end
         MODE_PREV: begin
            cand   = cand && e_id < req_ff.job_id;
            better = !best_ok_ff || e_id > best_id_ff;
         end
         default: begin
            cand = cand && e_id == req_ff.job_id;
            better = 1'b0;
         end
      endcase
   end

   logic [SLICE_W-1:0] sl_eff;
   logic [ID_W-1:0] rem, nx_ex, run_ex, run_tot;
   logic [SLICE_W-1:0] sl_start, sl_next;
   logic [AW-1:0] act_slot;
   logic finish;
   assign sl_eff = (slice_cfg_ff == '0) ? SLICE_W'(1) : slice_cfg_ff;
   always_comb begin
      run_ex  = tick_run_ff ? e_ex  : best_ex_ff;
      run_tot = tick_run_ff ? e_tot : best_tot_ff;
      act_slot = tick_run_ff ? run_slot_ff : best_slot_ff;
      rem = (run_tot > run_ex) ? run_tot - run_ex : '0;
      sl_start = (rem < ID_W'(sl_eff)) ? rem[SLICE_W-1:0] : sl_eff;
      nx_ex = (run_ex < run_tot) ? run_ex + ID_W'(1) : run_ex;
      sl_next = tick_run_ff ? slice_left_ff : sl_start;
      if (sl_next != '0) sl_next = sl_next - SLICE_W'(1);
      finish = nx_ex >= run_tot;
   end

   logic start_tick;
   assign start_tick = (state_ff == ST_ACT) && req_ff.mode == MODE_TICK &&
                       (tick_run_ff || best_ok_ff);
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_slot_ff;
      wr_data = {req_ff.job_id, {ID_W{1'b0}}, req_ff.time_or_upper};
      if (state_ff == ST_ACT) begin
         if (req_ff.mode == MODE_INSERT) begin
            wr_en = free_ok_ff && !dup_ff && req_ff.time_or_upper != '0;
         end else if (start_tick) begin
            wr_en   = 1'b1;
            wr_addr = act_slot;
            wr_data = {tick_run_ff ? e_id : best_id_ff, nx_ex, run_tot};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SCAN;
         ST_SCAN: if (scan_done) state_in = ST_LAST;
         ST_LAST: state_in = ST_ACT;
         ST_ACT: begin
            if (req_ff.mode == MODE_INSERT || req_ff.mode == MODE_TICK ||
                req_ff.mode > MODE_PREV) state_in = ST_IDLE;
            else state_in = ST_EMIT;
         end
         ST_EMIT: if (!rsp_valid_ff || !rsp_stall) begin
            state_in = ST_IDLE;
            if (req_ff.mode == MODE_RANGE && best_ok_ff && more_ff &&
                count_ff != KW'(RESULT_CAP - 1)) state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_SCAN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         slice_cfg_ff  <= SLICE_RESET;
         running_ff    <= 1'b0;
         run_slot_ff   <= '0;
         slice_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == {REG_TIME_SLICE, 1'b0})
            slice_cfg_ff <= csr_pwdata[SLICE_W-1:0];
         if (state_ff == ST_EMIT && state_in != ST_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         rd_pend_ff <= (state_ff == ST_SCAN) && !scan_done;
         if (state_ff == ST_ACT && req_ff.mode == MODE_INSERT && wr_en)
            valid_ff[free_slot_ff] <= 1'b1;
         if (start_tick) begin
            running_ff    <= !finish && sl_next != '0;
            run_slot_ff   <= act_slot;
            slice_left_ff <= finish ? '0 : sl_next;
            if (finish) valid_ff[act_slot] <= 1'b0;
         end else if (state_ff == ST_ACT && req_ff.mode == MODE_TICK) begin
            running_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= scan_ff[AW-1:0];
      if (state_ff == ST_IDLE) begin
         req_ff     <= req_data;
         lo_ff      <= {1'b0, req_data.job_id};
         count_ff   <= '0;
         tick_run_ff <= running_ff && valid_ff[run_slot_ff];
      end
      if (state_ff == ST_IDLE || state_ff == ST_WAIT) begin
         scan_ff    <= '0;
         best_ok_ff <= 1'b0;
         more_ff    <= 1'b0;
         free_ok_ff <= 1'b0;
         dup_ff     <= 1'b0;
      end
      if (state_ff == ST_SCAN && !scan_done) scan_ff <= scan_ff + CW'(1);
      if (rd_pend_ff) begin
         if (!valid_ff[rd_slot_ff] && !free_ok_ff) begin
            free_ok_ff   <= 1'b1;
            free_slot_ff <= rd_slot_ff;
         end
         if (valid_ff[rd_slot_ff] && e_id == req_ff.job_id) dup_ff <= 1'b1;
         if (cand && best_ok_ff) more_ff <= 1'b1;
         if (cand && better) begin
            best_ok_ff   <= 1'b1;
            best_slot_ff <= rd_slot_ff;
            best_id_ff   <= e_id;
            best_ex_ff   <= e_ex;
            best_tot_ff  <= e_tot;
         end
      end
      if (state_ff == ST_ACT && req_ff.mode == MODE_RANGE &&
          req_ff.job_id > req_ff.time_or_upper) best_ok_ff <= 1'b0;
      if (state_ff == ST_EMIT && state_in != ST_EMIT) begin
         rsp_ff.out_job_id    <= best_ok_ff ? best_id_ff : '0;
         rsp_ff.executed_time <= best_ok_ff ? best_ex_ff : '0;
         rsp_ff.need_time     <= best_ok_ff ? best_tot_ff : '0;
         rsp_ff.found         <= best_ok_ff;
         rsp_ff.last          <= (state_in != ST_WAIT);
         lo_ff    <= {1'b0, best_id_ff} + (ID_W+1)'(1);
         count_ff <= count_ff + KW'(1);
      end
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");
   a_tick_write: assert property (@(posedge clock) disable iff (reset)
      start_tick |-> wr_en) else $error("tick without writeback");
   a_slice_bound: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (slice_left_ff != '0)) else $error("running with no slice");
`endif

endmodule

// ===== sv/lrtjs_ram.sv =====
module lrtjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
